### rtl/core/refcounted_region_map_table_core_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef REFCOUNTED_REGION_MAP_TABLE_CORE_DEFINES_SVH
`define REFCOUNTED_REGION_MAP_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRMT_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRMT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/core/rrmt_pkg.sv
package rrmt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int REF_BITS = 16;

	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int IOVA_W = 64;
	localparam int SIZE_W = 22;
	localparam int VADDR_W = 64;
	localparam int STATUS_W = 3;
	localparam int SHOW_W = 16;
	localparam int USED_W = 7;

	localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
	localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

	localparam logic [STATUS_W-1:0] ST_NEW_MAP = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REF_UP = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REF_DOWN = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNMAP = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd5;
	localparam logic [STATUS_W-1:0] ST_REF_OVF = 3'd6;
	localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd7;

	localparam logic OP_MAP = 1'b0;
	localparam logic OP_UNMAP = 1'b1;

	typedef struct packed {
		logic accept;
		logic fire;
		logic en;
		logic unmap;
	} cell_ctl_t;

	function automatic logic [SHOW_W-1:0] show_refs(input logic [REF_BITS-1:0] r);
		logic [REF_BITS+SHOW_W-1:0] wide;
		wide = (REF_BITS + SHOW_W)'(r);
		if (wide > (REF_BITS + SHOW_W)'({SHOW_W{1'b1}})) begin
			return {SHOW_W{1'b1}};
		end
		return SHOW_W'(r);
	endfunction

endpackage

### rtl/core/rrmt_cell.sv
module rrmt_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rrmt_pkg::cell_ctl_t              ctl,
	input  logic                             valid,
	input  logic                             ins,
	input  logic [rrmt_pkg::IOVA_W-1:0]      cmp_iova,
	input  logic [rrmt_pkg::SIZE_W-1:0]      cmp_size,
	input  logic [rrmt_pkg::IOVA_W-1:0]      ld_iova,
	input  logic [rrmt_pkg::SIZE_W-1:0]      ld_size,
	input  logic                             shift_in,
	output logic                             shift_out,
	input  logic [rrmt_pkg::REF_BITS-1:0]    refs_in,
	output logic [rrmt_pkg::REF_BITS-1:0]    refs_out,
	input  logic [rrmt_pkg::IOVA_W-1:0]      nb_iova,
	input  logic [rrmt_pkg::SIZE_W-1:0]      nb_size,
	input  logic [rrmt_pkg::REF_BITS-1:0]    nb_refs,
	output logic [rrmt_pkg::IOVA_W-1:0]      own_iova,
	output logic [rrmt_pkg::SIZE_W-1:0]      own_size,
	output logic [rrmt_pkg::REF_BITS-1:0]    own_refs,
	output logic                             match
);
	import rrmt_pkg::*;

	logic [IOVA_W-1:0] iova_q;
	logic [SIZE_W-1:0] size_q;
	logic [REF_BITS-1:0] refs_q;
	logic hit_s1;
	logic drop;

	assign match = valid && (cmp_iova == iova_q) && (cmp_size == size_q);
	assign drop = ctl.unmap && hit_s1 && (refs_q == REF_ONE);
	assign shift_out = shift_in || drop;
	assign refs_out = refs_in | (hit_s1 ? refs_q : '0);

	assign own_iova = iova_q;
	assign own_size = size_q;
	assign own_refs = refs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (ctl.accept) begin
			hit_s1 <= match;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire && ctl.en) begin
			priority if (shift_out) begin
				iova_q <= nb_iova;
				size_q <= nb_size;
				refs_q <= nb_refs;
			end else if (hit_s1) begin
				if (ctl.unmap) begin
					refs_q <= refs_q - REF_ONE;
				end else if (refs_q != REF_MAX) begin
					refs_q <= refs_q + REF_ONE;
				end
			end else if (ins) begin
				iova_q <= ld_iova;
				size_q <= ld_size;
				refs_q <= REF_ONE;
			end else begin
				refs_q <= refs_q;
			end
		end
	end

endmodule

### rtl/core/refcounted_region_map_table_core.sv
// Reference-counted region map table. Each transaction maps or unmaps one region, named by its
// base and size, against a row of cells that hold the mapped regions in order with their counts.
// At the accept edge every cell compares the request against its entry; at the fire edge, once
// the output register is free, the row updates while enabled, inserting at the end or shifting
// down to close a gap, while the result is loaded into the output register. The next transaction
// is accepted in the cycle after that update, and no request is taken while one is in flight;
// a waiting result holds the update until the output register frees. The table needs no
// clearing pass after reset, and the enable register may be written only while the block is idle.
module refcounted_region_map_table_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic                             op,
	input  logic [rrmt_pkg::IOVA_W-1:0]      region_iova,
	input  logic [rrmt_pkg::SIZE_W-1:0]      region_size,
	input  logic [rrmt_pkg::VADDR_W-1:0]     virt_addr,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [rrmt_pkg::STATUS_W-1:0]    status,
	output logic [rrmt_pkg::IOVA_W-1:0]      cmd_iova,
	output logic [rrmt_pkg::SIZE_W-1:0]      cmd_size,
	output logic [rrmt_pkg::VADDR_W-1:0]     cmd_virt_addr,
	output logic [rrmt_pkg::SHOW_W-1:0]      ref_count,
	output logic [rrmt_pkg::USED_W-1:0]      entries_used
);
	import rrmt_pkg::*;

	logic en_q;
	logic busy_q;
	logic rsp_valid_q;
	logic [CNT_W-1:0] used_q;
	logic hit_any_s1;

	logic req_op_q;
	logic [IOVA_W-1:0] req_iova_q;
	logic [SIZE_W-1:0] req_size_q;
	logic [VADDR_W-1:0] req_vaddr_q;

	logic [STATUS_W-1:0] status_q;
	logic [IOVA_W-1:0] cmd_iova_q;
	logic [SIZE_W-1:0] cmd_size_q;
	logic [VADDR_W-1:0] cmd_vaddr_q;
	logic [SHOW_W-1:0] ref_count_q;

	logic accept;
	logic fire;
	logic ins_go;
	cell_ctl_t ctl;

	logic [TABLE_ENTRIES-1:0] match_vec;
	logic [TABLE_ENTRIES-1:0] valid_vec;
	logic [TABLE_ENTRIES-1:0] ins_vec;
	logic [TABLE_ENTRIES:0] shift_chain;
	logic [REF_BITS-1:0] refs_chain [TABLE_ENTRIES+1];
	logic [IOVA_W-1:0] row_iova [TABLE_ENTRIES+1];
	logic [SIZE_W-1:0] row_size [TABLE_ENTRIES+1];
	logic [REF_BITS-1:0] row_refs [TABLE_ENTRIES+1];

	logic [REF_BITS-1:0] found_refs;
	logic [STATUS_W-1:0] status_d;
	logic [REF_BITS-1:0] refs_d;
	logic [CNT_W-1:0] used_d;
	logic cmd_d;

	assign accept = req_valid && req_ready;
	assign req_ready = !busy_q;
	assign fire = busy_q && (!rsp_valid_q || rsp_ready);
	assign ins_go = (req_op_q == OP_MAP) && !hit_any_s1 && (used_q != CNT_FULL);

	always_comb begin
		ctl.accept = accept;
		ctl.fire = fire;
		ctl.en = en_q;
		ctl.unmap = (req_op_q == OP_UNMAP);
	end

	assign shift_chain[0] = 1'b0;
	assign refs_chain[0] = '0;
	assign row_iova[TABLE_ENTRIES] = '0;
	assign row_size[TABLE_ENTRIES] = '0;
	assign row_refs[TABLE_ENTRIES] = '0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		assign valid_vec[i] = (used_q > CNT_W'(i));
		assign ins_vec[i] = ins_go && (used_q == CNT_W'(i));

		rrmt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.valid     (valid_vec[i]),
			.ins       (ins_vec[i]),
			.cmp_iova  (region_iova),
			.cmp_size  (region_size),
			.ld_iova   (req_iova_q),
			.ld_size   (req_size_q),
			.shift_in  (shift_chain[i]),
			.shift_out (shift_chain[i+1]),
			.refs_in   (refs_chain[i]),
			.refs_out  (refs_chain[i+1]),
			.nb_iova   (row_iova[i+1]),
			.nb_size   (row_size[i+1]),
			.nb_refs   (row_refs[i+1]),
			.own_iova  (row_iova[i]),
			.own_size  (row_size[i]),
			.own_refs  (row_refs[i]),
			.match     (match_vec[i])
		);
	end

	assign found_refs = refs_chain[TABLE_ENTRIES];

	always_comb begin
		status_d = ST_DISABLED;
		refs_d = '0;
		used_d = used_q;
		cmd_d = 1'b0;
		priority if (!en_q) begin
			status_d = ST_DISABLED;
		end else if (req_op_q == OP_MAP) begin
			priority if (hit_any_s1) begin
				if (found_refs == REF_MAX) begin
					status_d = ST_REF_OVF;
					refs_d = REF_MAX;
				end else begin
					status_d = ST_REF_UP;
					refs_d = found_refs + REF_ONE;
				end
			end else if (used_q == CNT_FULL) begin
				status_d = ST_FULL;
			end else begin
				status_d = ST_NEW_MAP;
				refs_d = REF_ONE;
				used_d = used_q + CNT_W'(1);
				cmd_d = 1'b1;
			end
		end else begin
			priority if (!hit_any_s1) begin
				status_d = ST_NOT_MAPPED;
			end else if (found_refs == REF_ONE) begin
				status_d = ST_UNMAP;
				used_d = used_q - CNT_W'(1);
				cmd_d = 1'b1;
			end else begin
				status_d = ST_REF_DOWN;
				refs_d = found_refs - REF_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			busy_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			used_q <= '0;
			hit_any_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
				hit_any_s1 <= |match_vec;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
				used_q <= used_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q <= op;
			req_iova_q <= region_iova;
			req_size_q <= region_size;
			req_vaddr_q <= virt_addr;
		end
		if (fire) begin
			status_q <= status_d;
			cmd_iova_q <= cmd_d ? req_iova_q : '0;
			cmd_size_q <= cmd_d ? req_size_q : '0;
			cmd_vaddr_q <= (cmd_d && (req_op_q == OP_MAP)) ? req_vaddr_q : '0;
			ref_count_q <= show_refs(refs_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign cmd_iova = cmd_iova_q;
	assign cmd_size = cmd_size_q;
	assign cmd_virt_addr = cmd_vaddr_q;
	assign ref_count = ref_count_q;
	assign entries_used = USED_W'(used_q);

endmodule

### rtl/core/rrmt_checker.sv
`include "refcounted_region_map_table_core_defines.svh"

module rrmt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [rrmt_pkg::STATUS_W-1:0]    status,
	input logic [rrmt_pkg::SIZE_W-1:0]      cmd_size,
	input logic [rrmt_pkg::VADDR_W-1:0]     cmd_virt_addr,
	input logic [rrmt_pkg::SHOW_W-1:0]      ref_count
);
	import rrmt_pkg::*;

	`RRMT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "A pending response transaction was dropped.")
	`RRMT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready, "A request transaction was accepted during an update.")
	`RRMT_ASSERT_NOW(a_disabled_quiet, clk, arst_n, rsp_valid && (status == ST_DISABLED), (cmd_size == '0) && (ref_count == '0), "A disabled response carries a command or a count.")
	`RRMT_ASSERT_NOW(a_new_map_count, clk, arst_n, rsp_valid && (status == ST_NEW_MAP), ref_count == SHOW_W'(1), "A new mapping does not show a count of one.")
	`RRMT_ASSERT_NOW(a_unmap_fields, clk, arst_n, rsp_valid && (status == ST_UNMAP), (ref_count == '0) && (cmd_virt_addr == '0), "An unmap command shows a count or a virtual address.")

endmodule

bind refcounted_region_map_table_core rrmt_checker u_rrmt_checker (.*);

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import rrmt_pkg::*;

	localparam int LIMIT_CYCLES = 1500000;
	localparam int POOL_SIZE = 40;
	localparam logic [SIZE_W-1:0] SIZE_2M = 22'd2097152;

	typedef struct packed {
		logic                op;
		logic [IOVA_W-1:0]   iova;
		logic [SIZE_W-1:0]   size;
		logic [VADDR_W-1:0]  vaddr;
	} map_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IOVA_W-1:0]   iova;
		logic [SIZE_W-1:0]   size;
		logic [VADDR_W-1:0]  vaddr;
		logic [SHOW_W-1:0]   refs;
		logic [USED_W-1:0]   used;
	} map_rsp_t;

	typedef struct packed {
		logic     is_cfg;
		logic     en;
		map_req_t req;
		logic     typed;
		map_rsp_t want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_wdata;
	logic                req_valid;
	logic                req_ready;
	logic                op;
	logic [IOVA_W-1:0]   region_iova;
	logic [SIZE_W-1:0]   region_size;
	logic [VADDR_W-1:0]  virt_addr;
	logic                rsp_valid;
	logic                rsp_ready;
	logic [STATUS_W-1:0] status;
	logic [IOVA_W-1:0]   cmd_iova;
	logic [SIZE_W-1:0]   cmd_size;
	logic [VADDR_W-1:0]  cmd_virt_addr;
	logic [SHOW_W-1:0]   ref_count;
	logic [USED_W-1:0]   entries_used;

	// Mirror of the region table.
	logic [IOVA_W-1:0]   mirror_iova [TABLE_ENTRIES];
	logic [SIZE_W-1:0]   mirror_size [TABLE_ENTRIES];
	logic [REF_BITS-1:0] mirror_refs [TABLE_ENTRIES];
	int                  mirror_used = 0;
	logic                mirror_enabled = 1'b0;

	plan_row_t plan[$];
	plan_row_t req_fifo[$];
	plan_row_t cur;
	map_rsp_t  pending_outcomes[$];
	map_req_t  region_pool [POOL_SIZE];

	bit holding = 1'b0;
	bit req_took = 1'b0;
	bit calm = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int mismatches = 0;
	int accepted_n = 0;
	int checked_n = 0;
	int cycle_count = 0;
	int status_seen [8];

	refcounted_region_map_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.op(op),
		.region_iova(region_iova),
		.region_size(region_size),
		.virt_addr(virt_addr),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.cmd_iova(cmd_iova),
		.cmd_size(cmd_size),
		.cmd_virt_addr(cmd_virt_addr),
		.ref_count(ref_count),
		.entries_used(entries_used)
	);

	always #1 clk = ~clk;

	function automatic map_rsp_t predict_map_update(input map_req_t q);
		map_rsp_t o;
		int at;
		o = '0;
		o.status = ST_DISABLED;
		at = -1;
		if (mirror_enabled) begin
			for (int k = 0; k < mirror_used; k++) begin
				if (at < 0 && mirror_iova[k] == q.iova && mirror_size[k] == q.size) begin
					at = k;
				end
			end
			if (q.op == OP_MAP) begin
				if (at >= 0) begin
					if (mirror_refs[at] == REF_MAX) begin
						o.status = ST_REF_OVF;
					end else begin
						mirror_refs[at] = mirror_refs[at] + 1'b1;
						o.status = ST_REF_UP;
					end
					o.refs = SHOW_W'(mirror_refs[at]);
				end else if (mirror_used >= TABLE_ENTRIES) begin
					o.status = ST_FULL;
				end else begin
					mirror_iova[mirror_used] = q.iova;
					mirror_size[mirror_used] = q.size;
					mirror_refs[mirror_used] = REF_ONE;
					mirror_used++;
					o.status = ST_NEW_MAP;
					o.iova = q.iova;
					o.size = q.size;
					o.vaddr = q.vaddr;
					o.refs = 1;
				end
			end else if (at < 0) begin
				o.status = ST_NOT_MAPPED;
			end else begin
				mirror_refs[at] = mirror_refs[at] - 1'b1;
				if (mirror_refs[at] == 0) begin
					for (int k = at; k < mirror_used - 1; k++) begin
						mirror_iova[k] = mirror_iova[k + 1];
						mirror_size[k] = mirror_size[k + 1];
						mirror_refs[k] = mirror_refs[k + 1];
					end
					mirror_used--;
					o.status = ST_UNMAP;
					o.iova = q.iova;
					o.size = q.size;
				end else begin
					o.status = ST_REF_DOWN;
					o.refs = SHOW_W'(mirror_refs[at]);
				end
			end
		end
		o.used = USED_W'(mirror_used);
		return o;
	endfunction

	function automatic map_req_t mk_req(input logic o, input logic [IOVA_W-1:0] i,
			input logic [SIZE_W-1:0] z, input logic [VADDR_W-1:0] v);
		map_req_t q;
		q.op = o;
		q.iova = i;
		q.size = z;
		q.vaddr = v;
		return q;
	endfunction

	function automatic map_rsp_t outcome(input logic [STATUS_W-1:0] s,
			input logic [IOVA_W-1:0] i, input logic [SIZE_W-1:0] z,
			input logic [VADDR_W-1:0] v, input logic [SHOW_W-1:0] r,
			input logic [USED_W-1:0] u);
		map_rsp_t o;
		o.status = s;
		o.iova = i;
		o.size = z;
		o.vaddr = v;
		o.refs = r;
		o.used = u;
		return o;
	endfunction

	function automatic plan_row_t as_row(input map_req_t q, input logic typed, input map_rsp_t w);
		plan_row_t r;
		r = '0;
		r.req = q;
		r.typed = typed;
		r.want = w;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic en);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.en = en;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 40);
	endfunction

	function automatic map_req_t random_region(input logic o);
		logic [SIZE_W-1:0] z;
		case ($urandom_range(0, 9))
			0: z = 1;
			1: z = SIZE_2M;
			2: z = 0;
			3: z = {SIZE_W{1'b1}};
			4: z = SIZE_W'($urandom_range(0, 32'h3FFFFF));
			default: z = SIZE_W'(4096 * $urandom_range(1, 512));
		endcase
		return mk_req(o, rand64(), z, rand64());
	endfunction

	function automatic map_req_t random_request();
		map_req_t q;
		int r;
		int k;
		r = $urandom_range(0, 99);
		q = region_pool[$urandom_range(0, POOL_SIZE - 1)];
		q.vaddr = rand64();
		if (r < 50) begin
			q.op = OP_MAP;
		end else if (r < 82) begin
			q.op = OP_UNMAP;
		end else if (r < 90 && mirror_used > 0) begin
			k = $urandom_range(0, mirror_used - 1);
			q = mk_req(OP_UNMAP, mirror_iova[k], mirror_size[k], rand64());
		end else if (r < 96) begin
			if ($urandom_range(0, 1) != 0) begin
				q.size = q.size + 1'b1;
			end else begin
				q.iova = q.iova ^ (64'd1 << $urandom_range(0, 63));
			end
			q.op = logic'($urandom_range(0, 1));
		end else begin
			q = mk_req(logic'($urandom_range(0, 1)), rand64(),
				SIZE_W'($urandom_range(0, 32'h3FFFFF)), rand64());
		end
		return q;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 40) begin
			$display("%0t: %s got %0h, want %0h", $realtime, what, got, want);
		end
	endtask

	task automatic push_item(input plan_row_t r);
		while (req_fifo.size() >= 2) @(negedge clk);
		req_fifo.push_back(r);
	endtask

	task automatic settle();
		while (req_fifo.size() != 0 || holding || pending_outcomes.size() != 0) begin
			@(negedge clk);
		end
		repeat (2) @(negedge clk);
	endtask

	task automatic write_translation(input logic en);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin : observe
		map_req_t seen;
		map_rsp_t p;
		if (arst_n) begin
			if (cfg_we) begin
				mirror_enabled = cfg_wdata;
			end
			req_took = req_valid && req_ready;
			if (req_took) begin
				seen = mk_req(op, region_iova, region_size, virt_addr);
				p = predict_map_update(seen);
				if (cur.typed) begin
					p = cur.want;
				end
				pending_outcomes.push_back(p);
				accepted_n++;
			end
			if (rsp_valid && rsp_ready) begin
				checked_n++;
				status_seen[status]++;
				if (pending_outcomes.size() == 0) begin
					report_mismatch("unexpected transaction, status", status, 0);
				end else begin
					p = pending_outcomes.pop_front();
					if (status !== p.status) report_mismatch("status", status, p.status);
					if (cmd_iova !== p.iova) report_mismatch("cmd_iova", cmd_iova, p.iova);
					if (cmd_size !== p.size) report_mismatch("cmd_size", cmd_size, p.size);
					if (cmd_virt_addr !== p.vaddr) begin
						report_mismatch("cmd_virt_addr", cmd_virt_addr, p.vaddr);
					end
					if (ref_count !== p.refs) report_mismatch("ref_count", ref_count, p.refs);
					if (entries_used !== p.used) begin
						report_mismatch("entries_used", entries_used, p.used);
					end
				end
			end
		end
	end

	initial begin
		req_valid = 1'b0;
		op = OP_MAP;
		region_iova = '0;
		region_size = '0;
		virt_addr = '0;
		cur = '0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!(req_valid && !req_took)) begin
				if (req_valid) begin
					holding = 1'b0;
					gap_left = draw_gap();
				end
				if (gap_left > 0 || req_fifo.size() == 0) begin
					if (gap_left > 0) begin
						gap_left--;
					end
					req_valid <= 1'b0;
				end else begin
					cur = req_fifo.pop_front();
					holding = 1'b1;
					op <= cur.req.op;
					region_iova <= cur.req.iova;
					region_size <= cur.req.size;
					virt_addr <= cur.req.vaddr;
					req_valid <= 1'b1;
				end
			end
		end
	end

	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
				stall_left = draw_gap();
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		map_req_t drain_list[$];
		map_req_t anchor;
		int need;
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		foreach (status_seen[s]) status_seen[s] = 0;
		foreach (region_pool[s]) region_pool[s] = random_region(OP_MAP);

		plan.push_back(as_row(mk_req(OP_MAP, '0, 1, '1), 1,
			outcome(ST_DISABLED, '0, '0, '0, '0, '0)));
		plan.push_back(as_row(mk_req(OP_UNMAP, '1, SIZE_2M, '0), 1,
			outcome(ST_DISABLED, '0, '0, '0, '0, '0)));
		plan.push_back(cfg_row(1'b1));
		plan.push_back(as_row(mk_req(OP_UNMAP, 64'h1000, 4096, '1), 1,
			outcome(ST_NOT_MAPPED, '0, '0, '0, '0, '0)));
		plan.push_back(as_row(mk_req(OP_MAP, '0, 1, '1), 1,
			outcome(ST_NEW_MAP, '0, 1, '1, 1, 1)));
		plan.push_back(as_row(mk_req(OP_MAP, '1, SIZE_2M, '0), 1,
			outcome(ST_NEW_MAP, '1, SIZE_2M, '0, 1, 2)));
		plan.push_back(as_row(mk_req(OP_MAP, '0, 1, 64'h0123456789abcdef), 0, '0));
		plan.push_back(as_row(mk_req(OP_MAP, {32{2'b01}}, 0, {32{2'b10}}), 0, '0));
		plan.push_back(as_row(mk_req(OP_MAP, {32{2'b10}}, '1, {32{2'b01}}), 0, '0));
		plan.push_back(as_row(mk_req(OP_MAP, '0, 2, 64'h42), 0, '0));
		plan.push_back(as_row(mk_req(OP_MAP, 64'd1, 1, 64'h43), 0, '0));
		plan.push_back(as_row(mk_req(OP_UNMAP, '0, 1, '1), 0, '0));
		plan.push_back(as_row(mk_req(OP_UNMAP, '0, 1, '1), 0, '0));
		plan.push_back(as_row(mk_req(OP_UNMAP, '0, 1, '0), 0, '0));
		plan.push_back(as_row(mk_req(OP_MAP, '1, SIZE_2M, '1), 0, '0));
		plan.push_back(as_row(mk_req(OP_UNMAP, {32{2'b01}}, 0, '1), 0, '0));
		plan.push_back(as_row(mk_req(OP_UNMAP, {32{2'b01}}, 0, '0), 0, '0));
		plan.push_back(cfg_row(1'b0));
		plan.push_back(as_row(mk_req(OP_MAP, '0, 2, '1), 0, '0));
		plan.push_back(as_row(mk_req(OP_UNMAP, '1, SIZE_2M, '0), 0, '0));
		plan.push_back(cfg_row(1'b1));
		plan.push_back(as_row(mk_req(OP_UNMAP, '1, SIZE_2M, '0), 0, '0));
		plan.push_back(as_row(mk_req(OP_UNMAP, '1, SIZE_2M, '1), 0, '0));

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				write_translation(plan[i].en);
			end else begin
				push_item(plan[i]);
			end
		end

		// Random phases; two of them run with translation off over a live table.
		for (int blk = 0; blk < 9; blk++) begin
			write_translation(blk % 4 != 2);
			calm = ($urandom_range(0, 3) == 0);
			repeat ((blk % 4 != 2) ? 95 : 20) begin
				push_item(as_row(random_request(), 0, '0));
			end
		end
		calm = 1'b0;

		// Fill the table to capacity and push past it.
		write_translation(1'b1);
		need = TABLE_ENTRIES - mirror_used + 3;
		anchor = random_region(OP_MAP);
		push_item(as_row(anchor, 0, '0));
		repeat (need - 1) push_item(as_row(random_region(OP_MAP), 0, '0));
		anchor.vaddr = rand64();
		push_item(as_row(anchor, 0, '0));
		push_item(as_row(random_region(OP_UNMAP), 0, '0));

		// Release every reference, in random order so removals hit positions across the table.
		settle();
		for (int e = 0; e < mirror_used; e++) begin
			repeat (int'(mirror_refs[e])) begin
				drain_list.push_back(mk_req(OP_UNMAP, mirror_iova[e], mirror_size[e], rand64()));
			end
		end
		while (drain_list.size() != 0) begin
			k = $urandom_range(0, drain_list.size() - 1);
			push_item(as_row(drain_list[k], 0, '0));
			drain_list.delete(k);
		end

		// One last request after translation is switched off again.
		write_translation(1'b0);
		push_item(as_row(anchor, 0, '0));

		settle();
		repeat (4) @(posedge clk);
		$display("Checked %0d results from %0d requests in %0d cycles, across enable toggling, table fill and drain.",
			checked_n, accepted_n, cycle_count);
		$display("Status mix: new %0d, raised %0d, lowered %0d, unmapped %0d, miss %0d, full %0d, saturated %0d, off %0d",
			status_seen[ST_NEW_MAP], status_seen[ST_REF_UP], status_seen[ST_REF_DOWN],
			status_seen[ST_UNMAP], status_seen[ST_NOT_MAPPED], status_seen[ST_FULL],
			status_seen[ST_REF_OVF], status_seen[ST_DISABLED]);
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rrmt_pkg.sv
rtl/core/rrmt_cell.sv
rtl/core/refcounted_region_map_table_core.sv
rtl/core/rrmt_checker.sv
tb/testbench.sv
